// ----- rtl/core/min_max_palette_color_mapper_assert.svh -----
// ----------------------------------------------------------------------------
// min_max_palette_color_mapper assertion macros
// shared assertion forms for the mapper checkers
// ----------------------------------------------------------------------------
`ifndef MIN_MAX_PALETTE_COLOR_MAPPER_ASSERT_SVH
`define MIN_MAX_PALETTE_COLOR_MAPPER_ASSERT_SVH

// property that must hold at every clock edge outside reset
`define MMPCM_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// implication checked on the next cycle
`define MMPCM_ASSERT_NEXT(label, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
		else $error(msg);

`endif

// ----- rtl/core/mmpcm_pkg.sv -----
// ----------------------------------------------------------------------------
// mmpcm_pkg
// shared types and constants of the min/max palette color mapper
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mmpcm_pkg;

	// operation codes carried in tuser
	typedef enum logic [1:0] {
		OP_WRITE = 2'd0,
		OP_SCAN  = 2'd1,
		OP_MAP   = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	// configuration register indexes
	localparam logic CFG_COLOR_LEVELS = 1'b0;
	localparam logic CFG_GRAY_MODE    = 1'b1;

	localparam logic [7:0] LEVELS_RESET = 8'd255;
	localparam logic [7:0] GRAY_LEVELS  = 8'd255;

	localparam int PALETTE_ENTRIES = 256;
	localparam int PAL_AW          = $clog2(PALETTE_ENTRIES);

	// front to back queue, depth a power of two
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// one queued job: a palette write or a map with its offset and span
	typedef struct packed {
		logic               is_map;
		logic signed [32:0] num;
		logic signed [32:0] span;
		logic [7:0]         pal_index;
		logic [23:0]        rgb;
	} q_entry_t;

	// queue status seen by the front end and the back end
	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage

// ----- rtl/core/mmpcm_queue.sv -----
// ----------------------------------------------------------------------------
// mmpcm_queue
// short fifo of jobs between the front end and the back end
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mmpcm_queue import mmpcm_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  q_entry_t  push_data,
	input  logic      pop,
	output q_status_t status,
	output q_entry_t  head
);

	q_entry_t            slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   count_q;

	assign status.full  = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign status.empty = (count_q == '0);
	assign head         = slot_q[rd_ptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ----- rtl/core/mmpcm_front.sv -----
// ----------------------------------------------------------------------------
// mmpcm_front
// accepts input words, tracks the frame range and queues writes and maps
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mmpcm_front import mmpcm_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	input  logic [1:0]   operation,
	input  logic [31:0]  sample,
	input  logic         first_in_frame,
	input  logic [7:0]   palette_index,
	input  logic [23:0]  rgb,
	input  q_status_t    q_status,
	output logic         push,
	output q_entry_t     push_data
);

	logic signed [31:0] range_low_q;
	logic signed [31:0] range_high_q;
	logic               accept;
	logic signed [32:0] x_ext;
	op_t                op;

	assign in_ready = !q_status.full;
	assign accept   = in_valid && in_ready;
	assign op       = op_t'(operation);
	assign x_ext    = {sample[31], sample};

	// classify the word: writes and maps go to the back end
	always_comb begin
		push                = accept && (op == OP_WRITE || op == OP_MAP);
		push_data.is_map    = (op == OP_MAP);
		push_data.num       = x_ext - {range_low_q[31], range_low_q};
		push_data.span      = {range_high_q[31], range_high_q} - {range_low_q[31], range_low_q};
		push_data.pal_index = palette_index;
		push_data.rgb       = rgb;
	end

	// running minimum and maximum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_low_q  <= '0;
			range_high_q <= '0;
		end else if (accept && op == OP_SCAN) begin
			if (first_in_frame) begin
				range_low_q  <= $signed(sample);
				range_high_q <= $signed(sample);
			end else begin
				if ($signed(sample) > range_high_q) begin
					range_high_q <= $signed(sample);
				end
				if ($signed(sample) < range_low_q) begin
					range_low_q <= $signed(sample);
				end
			end
		end
	end

endmodule

// ----- rtl/core/mmpcm_back.sv -----
// ----------------------------------------------------------------------------
// mmpcm_back
// palette storage, serial quantizing divider and output register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mmpcm_back import mmpcm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [7:0]  cfg_data,
	input  q_status_t   q_status,
	input  q_entry_t    head,
	output logic        pop,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] out_data
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_DIV,
		ST_LOOK,
		ST_FIN
	} state_t;

	state_t             state_q;
	logic [7:0]         levels_q;
	logic               gray_q;
	logic signed [32:0] num_q;
	logic signed [32:0] span_q;
	logic [31:0]        div_q;
	logic [31:0]        rem_q;
	logic [7:0]         low_q;
	logic [7:0]         quot_q;
	logic [2:0]         cnt_q;
	logic               out_valid_q;
	logic [31:0]        out_data_q;

	logic [23:0]        pal_mem [PALETTE_ENTRIES];
	logic [23:0]        rd_data_q;

	logic [7:0]         lvl;
	logic [39:0]        prod;
	logic               span_le0;
	logic               num_le0;
	logic [32:0]        shifted;
	logic [33:0]        trial;
	logic               pal_wr;
	logic [PAL_AW+7:0]  wr_wide;
	logic [PAL_AW+7:0]  rd_wide;
	logic               rd_in_range;
	logic               out_free;

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;
	assign out_free  = !out_valid_q || out_ready;

	// pop on every queued job taken while idle
	assign pop    = (state_q == ST_IDLE) && !q_status.empty;
	assign pal_wr = pop && !head.is_map;

	// palette address range
	assign wr_wide     = {{PAL_AW{1'b0}}, head.pal_index};
	assign rd_wide     = {{PAL_AW{1'b0}}, quot_q};
	assign rd_in_range = rd_wide < (PAL_AW + 8)'(PALETTE_ENTRIES);

	// quantizer setup and one divider step
	always_comb begin
		lvl      = gray_q ? GRAY_LEVELS : levels_q;
		prod     = {32'd0, lvl} * {8'd0, num_q[31:0]};
		span_le0 = span_q[32] || (span_q == '0);
		num_le0  = num_q[32] || (num_q == '0);
		shifted  = {rem_q, low_q[7]};
		trial    = {1'b0, shifted} - {2'b00, div_q};
	end

	// palette memory with registered read
	always_ff @(posedge clk) begin
		if (pal_wr && wr_wide < (PAL_AW + 8)'(PALETTE_ENTRIES)) begin
			pal_mem[wr_wide[PAL_AW-1:0]] <= head.rgb;
		end
		rd_data_q <= pal_mem[rd_wide[PAL_AW-1:0]];
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			levels_q <= LEVELS_RESET;
			gray_q   <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_COLOR_LEVELS: levels_q <= cfg_data;
				CFG_GRAY_MODE:    gray_q   <= cfg_data[0];
				default:          levels_q <= levels_q;
			endcase
		end
	end

	// job sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			cnt_q       <= '0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (pop && head.is_map) begin
						num_q   <= head.num;
						span_q  <= head.span;
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					div_q <= span_q[31:0];
					cnt_q <= '0;
					if (span_le0 || num_le0) begin
						quot_q  <= '0;
						state_q <= ST_LOOK;
					end else if (num_q >= span_q) begin
						quot_q  <= lvl;
						state_q <= ST_LOOK;
					end else begin
						// quotient fits in eight bits since product < 256 * span
						rem_q   <= prod[39:8];
						low_q   <= prod[7:0];
						quot_q  <= '0;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (!trial[33]) begin
						rem_q  <= trial[31:0];
						quot_q <= {quot_q[6:0], 1'b1};
					end else begin
						rem_q  <= shifted[31:0];
						quot_q <= {quot_q[6:0], 1'b0};
					end
					low_q <= {low_q[6:0], 1'b0};
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == 3'd7) begin
						state_q <= ST_LOOK;
					end
				end
				ST_LOOK: begin
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						if (gray_q) begin
							out_data_q <= {quot_q, quot_q, quot_q, quot_q};
						end else if (rd_in_range) begin
							out_data_q <= {rd_data_q[7:0], rd_data_q[15:8],
								rd_data_q[23:16], quot_q};
						end else begin
							out_data_q <= {24'd0, quot_q};
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ----- rtl/core/min_max_palette_color_mapper.sv -----
// ----------------------------------------------------------------------------
// min_max_palette_color_mapper
// Maps a frame of signed samples to palette colors in two passes. Scan words
// track the frame minimum and maximum (first_in_frame reloads both) and are
// taken one per cycle while the job queue is not full. Map words give index =
// floor(L*(x-min)/(max-min)) clamped to 0..L, with L = color_levels, or 255 in
// gray mode where the index is returned as the gray value; an empty range gives
// index 0. Palette write words load one entry. Writes and maps pass through a
// two-entry job queue to the back end: a palette write is taken in the idle
// state, a map steps through setup, a multiply, the radix-2 divider, palette
// read and output load, and no new job is taken until it is done. Results leave
// through an output register, so the queue keeps taking words while one waits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module min_max_palette_color_mapper import mmpcm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [7:0]  cfg_data,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// sample[31:0], palette_index[39:32], new_red[47:40], new_green[55:48],
	// new_blue[63:56]
	input  logic [63:0] s_axis_tdata,
	// operation[1:0], first_in_frame[2]
	input  logic [2:0]  s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// color_index[7:0], red[15:8], green[23:16], blue[31:24]
	output logic [31:0] m_axis_tdata
);

	q_status_t q_status;
	logic      push;
	logic      pop;
	q_entry_t  push_data;
	q_entry_t  head;

	// front end: range tracking and job classification
	mmpcm_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (s_axis_tvalid),
		.in_ready       (s_axis_tready),
		.operation      (s_axis_tuser[1:0]),
		.sample         (s_axis_tdata[31:0]),
		.first_in_frame (s_axis_tuser[2]),
		.palette_index  (s_axis_tdata[39:32]),
		.rgb            ({s_axis_tdata[47:40], s_axis_tdata[55:48], s_axis_tdata[63:56]}),
		.q_status       (q_status),
		.push           (push),
		.push_data      (push_data)
	);

	// job queue
	mmpcm_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.status    (q_status),
		.head      (head)
	);

	// back end: palette, divider, output register
	mmpcm_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.q_status  (q_status),
		.head      (head),
		.pop       (pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata)
	);

endmodule

// ----- rtl/core/mmpcm_checker.sv -----
// ----------------------------------------------------------------------------
// mmpcm_checker
// port-level checks of the mapper, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "min_max_palette_color_mapper_assert.svh"

module mmpcm_checker import mmpcm_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        cfg_we,
	input logic        cfg_index,
	input logic [7:0]  cfg_data,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic [2:0]  s_axis_tuser,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [31:0] m_axis_tdata
);

	logic [3:0] pending_q;
	logic       gray_q;
	logic       map_in;
	logic       word_out;
	logic       out_stall;
	logic       gray_ok;

	assign map_in    = s_axis_tvalid && s_axis_tready && (s_axis_tuser[1:0] == OP_MAP);
	assign word_out  = m_axis_tvalid && m_axis_tready;
	assign out_stall = m_axis_tvalid && !m_axis_tready;

	// all three color bytes repeat the index
	assign gray_ok = (m_axis_tdata[15:8] == m_axis_tdata[7:0])
		&& (m_axis_tdata[23:16] == m_axis_tdata[7:0])
		&& (m_axis_tdata[31:24] == m_axis_tdata[7:0]);

	// map words accepted but not yet delivered, and gray mode as written
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
			gray_q    <= 1'b0;
		end else begin
			if (map_in && !word_out) begin
				pending_q <= pending_q + 1'b1;
			end else if (word_out && !map_in) begin
				pending_q <= pending_q - 1'b1;
			end
			if (cfg_we && cfg_index == CFG_GRAY_MODE) begin
				gray_q <= cfg_data[0];
			end
		end
	end

	`MMPCM_ASSERT_NEXT(a_out_hold, out_stall, m_axis_tvalid, "result word dropped in stall")
	`MMPCM_ASSERT_NEXT(a_out_stable, out_stall, $stable(m_axis_tdata), "result word changed in stall")
	`MMPCM_ASSERT(a_no_invented, !m_axis_tvalid || pending_q != '0, "result word with no map pending")
	`MMPCM_ASSERT(a_gray_equal, !(m_axis_tvalid && gray_q) || gray_ok, "gray channels differ from index")

endmodule

bind min_max_palette_color_mapper mmpcm_checker u_mmpcm_checker (.*);
